>>> rtl/sgi_pkg.sv
// sgi_pkg: widths, codes, transaction and pipeline stage types of the segment intersection unit
// no dependencies; imported by sgi_front, sgi_div_step and segment_intersection_unit
package sgi_pkg;

   localparam int CW  = 16;          // coordinate width
   localparam int FB  = 8;           // fraction bits of the result
   localparam int QW  = CW + FB;     // result field width, also quotient bits
   localparam int DW  = CW + 1;      // coordinate difference
   localparam int PW  = 2 * CW;      // coordinate product
   localparam int CPW = 2 * DW;      // difference product
   localparam int C1W = PW + 1;      // line constant
   localparam int XPW = C1W + DW;    // numerator partial product
   localparam int XW  = XPW + 1;     // numerator
   localparam int ZW  = CPW + 1;     // denominator
   localparam int NW  = XW + FB;     // scaled numerator magnitude

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_POINT   = 2'd1,
      KIND_SEGMENT = 2'd2
   } kind_type;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [QW-1:0]  fix_type;
   typedef logic signed [DW-1:0]  diff_type;
   typedef logic signed [PW-1:0]  prod_type;
   typedef logic signed [CPW-1:0] cross_type;
   typedef logic signed [C1W-1:0] line_type;
   typedef logic signed [XPW-1:0] xprod_type;
   typedef logic signed [XW-1:0]  wide_type;
   typedef logic signed [ZW-1:0]  den_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type cx;
      coord_type cy;
      coord_type dx;
      coord_type dy;
   } req_type;

   typedef struct packed {
      kind_type kind;
      fix_type  first_x;
      fix_type  first_y;
      fix_type  second_x;
      fix_type  second_y;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } pt_type;

   typedef struct packed {
      coord_type xlo1;
      coord_type xhi1;
      coord_type ylo1;
      coord_type yhi1;
      coord_type xlo2;
      coord_type xhi2;
      coord_type ylo2;
      coord_type yhi2;
   } box_type;

   typedef struct packed {
      diff_type  d1x;
      diff_type  d1y;
      diff_type  d2x;
      diff_type  d2y;
      prod_type  p1;
      prod_type  p2;
      prod_type  p3;
      prod_type  p4;
      diff_type  e_bax;
      diff_type  e_bay;
      diff_type  e_cax;
      diff_type  e_cay;
      diff_type  e_dax;
      diff_type  e_day;
      diff_type  e_dcx;
      diff_type  e_dcy;
      diff_type  e_acx;
      diff_type  e_acy;
      diff_type  e_bcx;
      diff_type  e_bcy;
      box_type   box;
      pt_type    amin;
      pt_type    amax;
      pt_type    cmin;
      pt_type    cmax;
   } s1_type;

   typedef struct packed {
      diff_type  d1x;
      diff_type  d1y;
      diff_type  d2x;
      diff_type  d2y;
      line_type  c1;
      line_type  c2;
      cross_type zp1;
      cross_type zp2;
      cross_type k1a;
      cross_type k1b;
      cross_type k2a;
      cross_type k2b;
      cross_type k3a;
      cross_type k3b;
      cross_type k4a;
      cross_type k4b;
      box_type   box;
      pt_type    lo;
      pt_type    hi;
   } s2_type;

   typedef struct packed {
      xprod_type xa;
      xprod_type xb;
      xprod_type ya;
      xprod_type yb;
      den_type   z;
      logic      coll;
      logic      rel_lt;
      logic      rel_eq;
      box_type   box;
      pt_type    lo;
      pt_type    hi;
   } s3_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      den_type  z;
      logic     zzero;
      kind_type col_kind;
      box_type  box;
      pt_type   lo;
      pt_type   hi;
   } s4_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      den_type  z;
      logic     zzero;
      kind_type col_kind;
      box_type  box;
      pt_type   lo;
      pt_type   hi;
   } s5_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      den_type  z;
      logic     zzero;
      kind_type col_kind;
      wide_type bx1lo;
      wide_type bx1hi;
      wide_type by1lo;
      wide_type by1hi;
      wide_type bx2lo;
      wide_type bx2hi;
      wide_type by2lo;
      wide_type by2hi;
      pt_type   lo;
      pt_type   hi;
   } s6_type;

   typedef struct packed {
      kind_type kind;
      logic     pt;
      pt_type   lo;
      pt_type   hi;
   } side_type;

   typedef struct packed {
      logic [ZW-1:0] rx;
      logic [ZW-1:0] ry;
      logic [QW-1:0] nx;
      logic [QW-1:0] ny;
      logic [QW-1:0] qx;
      logic [QW-1:0] qy;
      logic          negx;
      logic          negy;
      logic [ZW-1:0] z;
      side_type      side;
   } div_type;

   // lexicographic order, x first then y
   function automatic logic pt_lt(pt_type p, pt_type q);
      return ($signed(p.x) < $signed(q.x)) ||
             (($signed(p.x) == $signed(q.x)) && ($signed(p.y) < $signed(q.y)));
   endfunction

   function automatic diff_type sub_c(coord_type a, coord_type b);
      return DW'(a) - DW'(b);
   endfunction

   function automatic coord_type min_c(coord_type a, coord_type b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic coord_type max_c(coord_type a, coord_type b);
      return ($signed(a) < $signed(b)) ? b : a;
   endfunction

endpackage

>>> rtl/segment_intersection_unit.sv
// segment_intersection_unit: top level, geometry front end, divider pipeline, result register
// depends on sgi_pkg, sgi_front, sgi_div_step
// pipeline: 32 register stages (7 geometry, 24 divider, one result register), the first
//   loads at the req acceptance edge; one quotient bit per divider stage sets the depth
// throughput: one transaction per cycle while rsp_ready holds; every stage has its own valid bit and a stage
//   takes new data whenever it is empty or its successor moves
// reset: synchronous, clears only the valid bits; data registers are not reset
module segment_intersection_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgi_pkg::rsp_type rsp_data
);
   import sgi_pkg::*;

   // divider chain, index 0 is the front end output
   logic    div_valid [QW+1];
   logic    div_ready [QW+1];
   div_type div_data  [QW+1];

   div_type last;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;
   logic    out_take;

   // geometry: determinants, collinear overlap, containment against both boxes
   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // restoring division of the scaled numerators, msb of the quotient first
   for (genvar i = 0; i < QW; i++) begin : g_div
      sgi_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   // result register, parts the pipeline from the rsp side
   assign out_take      = !rsp_valid_ff || rsp_ready;
   assign div_ready[QW] = out_take;
   assign last          = div_data[QW];

   always_comb begin
      rsp_in.kind     = last.side.kind;
      rsp_in.first_x  = '0;
      rsp_in.first_y  = '0;
      rsp_in.second_x = '0;
      rsp_in.second_y = '0;
      if (last.side.pt) begin
         // crossing point, quotient gets the sign of the numerator back
         rsp_in.first_x = last.negx ? -last.qx : last.qx;
         rsp_in.first_y = last.negy ? -last.qy : last.qy;
      end else if (last.side.kind != KIND_NONE) begin
         // collinear overlap, the ends are whole coordinates
         rsp_in.first_x = {last.side.lo.x, FB'(0)};
         rsp_in.first_y = {last.side.lo.y, FB'(0)};
         if (last.side.kind == KIND_SEGMENT) begin
            rsp_in.second_x = {last.side.hi.x, FB'(0)};
            rsp_in.second_y = {last.side.hi.y, FB'(0)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= div_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && div_valid[QW]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no intersection carries all-zero coordinates
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_NONE) |->
         (rsp_data.first_x == '0 && rsp_data.first_y == '0 &&
          rsp_data.second_x == '0 && rsp_data.second_y == '0))
      else $error("no-intersection result with nonzero coordinates");

   // second point only for an overlapping part
   a_second_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_SEGMENT) |->
         (rsp_data.second_x == '0 && rsp_data.second_y == '0))
      else $error("second point set without overlap");

   // the input side only stalls when the whole pipe is full and the result waits
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while result side is free");

   // a result leaving the divider enters the result register in the same edge
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (div_valid[QW] && out_take) |=> rsp_valid)
      else $error("divider output lost at the result register");

endmodule

>>> rtl/sgi_front.sv
// sgi_front: seven geometry stages, determinants, collinear overlap, containment, divider setup
// depends on sgi_pkg
module sgi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgi_pkg::req_type req_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sgi_pkg::div_type out_data
);
   import sgi_pkg::*;

   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   s3_type  s3_in, s3_ff;
   s4_type  s4_in, s4_ff;
   s5_type  s5_in, s5_ff;
   s6_type  s6_in, s6_ff;
   div_type s7_in, s7_ff;
   logic [7:1] v_ff;
   logic [8:1] rdy;

   pt_type   pa, pb, pc, pd;
   den_type  on1, on2, on3, on4;
   logic     contain;
   wide_type magx, magy;
   logic [NW-1:0] numx, numy;

   assign rdy[8] = out_ready;
   always_comb begin
      for (int k = 1; k <= 7; k++) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign req_ready = rdy[1];

   // stage 1: differences, coordinate products, boxes, per-segment sort
   always_comb begin
      pa = '{x: req_data.ax, y: req_data.ay};
      pb = '{x: req_data.bx, y: req_data.by};
      pc = '{x: req_data.cx, y: req_data.cy};
      pd = '{x: req_data.dx, y: req_data.dy};
      s1_in.d1x   = sub_c(req_data.ax, req_data.bx);
      s1_in.d1y   = sub_c(req_data.ay, req_data.by);
      s1_in.d2x   = sub_c(req_data.cx, req_data.dx);
      s1_in.d2y   = sub_c(req_data.cy, req_data.dy);
      s1_in.p1    = PW'(req_data.ax) * PW'(req_data.by);
      s1_in.p2    = PW'(req_data.ay) * PW'(req_data.bx);
      s1_in.p3    = PW'(req_data.cx) * PW'(req_data.dy);
      s1_in.p4    = PW'(req_data.cy) * PW'(req_data.dx);
      s1_in.e_bax = sub_c(req_data.bx, req_data.ax);
      s1_in.e_bay = sub_c(req_data.by, req_data.ay);
      s1_in.e_cax = sub_c(req_data.cx, req_data.ax);
      s1_in.e_cay = sub_c(req_data.cy, req_data.ay);
      s1_in.e_dax = sub_c(req_data.dx, req_data.ax);
      s1_in.e_day = sub_c(req_data.dy, req_data.ay);
      s1_in.e_dcx = sub_c(req_data.dx, req_data.cx);
      s1_in.e_dcy = sub_c(req_data.dy, req_data.cy);
      s1_in.e_acx = sub_c(req_data.ax, req_data.cx);
      s1_in.e_acy = sub_c(req_data.ay, req_data.cy);
      s1_in.e_bcx = sub_c(req_data.bx, req_data.cx);
      s1_in.e_bcy = sub_c(req_data.by, req_data.cy);
      s1_in.box.xlo1 = min_c(req_data.ax, req_data.bx);
      s1_in.box.xhi1 = max_c(req_data.ax, req_data.bx);
      s1_in.box.ylo1 = min_c(req_data.ay, req_data.by);
      s1_in.box.yhi1 = max_c(req_data.ay, req_data.by);
      s1_in.box.xlo2 = min_c(req_data.cx, req_data.dx);
      s1_in.box.xhi2 = max_c(req_data.cx, req_data.dx);
      s1_in.box.ylo2 = min_c(req_data.cy, req_data.dy);
      s1_in.box.yhi2 = max_c(req_data.cy, req_data.dy);
      s1_in.amin  = pt_lt(pb, pa) ? pb : pa;
      s1_in.amax  = pt_lt(pb, pa) ? pa : pb;
      s1_in.cmin  = pt_lt(pd, pc) ? pd : pc;
      s1_in.cmax  = pt_lt(pd, pc) ? pc : pd;
   end

   // stage 2: line constants, denominator and collinearity products, overlap ends
   always_comb begin
      s2_in.d1x = s1_ff.d1x;
      s2_in.d1y = s1_ff.d1y;
      s2_in.d2x = s1_ff.d2x;
      s2_in.d2y = s1_ff.d2y;
      s2_in.c1  = C1W'(s1_ff.p1) - C1W'(s1_ff.p2);
      s2_in.c2  = C1W'(s1_ff.p3) - C1W'(s1_ff.p4);
      s2_in.zp1 = CPW'(s1_ff.d1x) * CPW'(s1_ff.d2y);
      s2_in.zp2 = CPW'(s1_ff.d1y) * CPW'(s1_ff.d2x);
      s2_in.k1a = CPW'(s1_ff.e_bax) * CPW'(s1_ff.e_cay);
      s2_in.k1b = CPW'(s1_ff.e_bay) * CPW'(s1_ff.e_cax);
      s2_in.k2a = CPW'(s1_ff.e_bax) * CPW'(s1_ff.e_day);
      s2_in.k2b = CPW'(s1_ff.e_bay) * CPW'(s1_ff.e_dax);
      s2_in.k3a = CPW'(s1_ff.e_dcx) * CPW'(s1_ff.e_acy);
      s2_in.k3b = CPW'(s1_ff.e_dcy) * CPW'(s1_ff.e_acx);
      s2_in.k4a = CPW'(s1_ff.e_dcx) * CPW'(s1_ff.e_bcy);
      s2_in.k4b = CPW'(s1_ff.e_dcy) * CPW'(s1_ff.e_bcx);
      s2_in.box = s1_ff.box;
      s2_in.lo  = pt_lt(s1_ff.amin, s1_ff.cmin) ? s1_ff.cmin : s1_ff.amin;
      s2_in.hi  = pt_lt(s1_ff.cmax, s1_ff.amax) ? s1_ff.cmax : s1_ff.amax;
   end

   // stage 3: numerator products, denominator, collinear test
   always_comb begin
      on1 = ZW'(s2_ff.k1a) - ZW'(s2_ff.k1b);
      on2 = ZW'(s2_ff.k2a) - ZW'(s2_ff.k2b);
      on3 = ZW'(s2_ff.k3a) - ZW'(s2_ff.k3b);
      on4 = ZW'(s2_ff.k4a) - ZW'(s2_ff.k4b);
      s3_in.xa     = XPW'(s2_ff.c1) * XPW'(s2_ff.d2x);
      s3_in.xb     = XPW'(s2_ff.d1x) * XPW'(s2_ff.c2);
      s3_in.ya     = XPW'(s2_ff.c1) * XPW'(s2_ff.d2y);
      s3_in.yb     = XPW'(s2_ff.d1y) * XPW'(s2_ff.c2);
      s3_in.z      = ZW'(s2_ff.zp1) - ZW'(s2_ff.zp2);
      s3_in.coll   = (on1 == '0) && (on2 == '0) && (on3 == '0) && (on4 == '0);
      s3_in.rel_lt = pt_lt(s2_ff.lo, s2_ff.hi);
      s3_in.rel_eq = (s2_ff.lo == s2_ff.hi);
      s3_in.box    = s2_ff.box;
      s3_in.lo     = s2_ff.lo;
      s3_in.hi     = s2_ff.hi;
   end

   // stage 4: numerators, collinear outcome
   always_comb begin
      s4_in.x     = XW'(s3_ff.xa) - XW'(s3_ff.xb);
      s4_in.y     = XW'(s3_ff.ya) - XW'(s3_ff.yb);
      s4_in.z     = s3_ff.z;
      s4_in.zzero = (s3_ff.z == '0);
      if (s3_ff.z == '0 && s3_ff.coll && s3_ff.rel_eq) begin
         s4_in.col_kind = KIND_POINT;
      end else if (s3_ff.z == '0 && s3_ff.coll && s3_ff.rel_lt) begin
         s4_in.col_kind = KIND_SEGMENT;
      end else begin
         s4_in.col_kind = KIND_NONE;
      end
      s4_in.box = s3_ff.box;
      s4_in.lo  = s3_ff.lo;
      s4_in.hi  = s3_ff.hi;
   end

   // stage 5: make the denominator positive, negating the numerators with it
   always_comb begin
      s5_in = s4_ff;
      if (s4_ff.z[ZW-1]) begin
         s5_in.x = -s4_ff.x;
         s5_in.y = -s4_ff.y;
         s5_in.z = -s4_ff.z;
      end
   end

   // stage 6: box bounds scaled by the denominator
   always_comb begin
      s6_in.x        = s5_ff.x;
      s6_in.y        = s5_ff.y;
      s6_in.z        = s5_ff.z;
      s6_in.zzero    = s5_ff.zzero;
      s6_in.col_kind = s5_ff.col_kind;
      s6_in.bx1lo    = XW'(s5_ff.box.xlo1) * XW'(s5_ff.z);
      s6_in.bx1hi    = XW'(s5_ff.box.xhi1) * XW'(s5_ff.z);
      s6_in.by1lo    = XW'(s5_ff.box.ylo1) * XW'(s5_ff.z);
      s6_in.by1hi    = XW'(s5_ff.box.yhi1) * XW'(s5_ff.z);
      s6_in.bx2lo    = XW'(s5_ff.box.xlo2) * XW'(s5_ff.z);
      s6_in.bx2hi    = XW'(s5_ff.box.xhi2) * XW'(s5_ff.z);
      s6_in.by2lo    = XW'(s5_ff.box.ylo2) * XW'(s5_ff.z);
      s6_in.by2hi    = XW'(s5_ff.box.yhi2) * XW'(s5_ff.z);
      s6_in.lo       = s5_ff.lo;
      s6_in.hi       = s5_ff.hi;
   end

   // stage 7: containment on both segments, divider operands
   always_comb begin
      contain = ($signed(s6_ff.bx1lo) <= $signed(s6_ff.x)) &&
                ($signed(s6_ff.x) <= $signed(s6_ff.bx1hi)) &&
                ($signed(s6_ff.by1lo) <= $signed(s6_ff.y)) &&
                ($signed(s6_ff.y) <= $signed(s6_ff.by1hi)) &&
                ($signed(s6_ff.bx2lo) <= $signed(s6_ff.x)) &&
                ($signed(s6_ff.x) <= $signed(s6_ff.bx2hi)) &&
                ($signed(s6_ff.by2lo) <= $signed(s6_ff.y)) &&
                ($signed(s6_ff.y) <= $signed(s6_ff.by2hi));
      magx = s6_ff.x[XW-1] ? -s6_ff.x : s6_ff.x;
      magy = s6_ff.y[XW-1] ? -s6_ff.y : s6_ff.y;
      numx = {magx, FB'(0)};
      numy = {magy, FB'(0)};
      s7_in.rx   = numx[NW-1:QW];
      s7_in.ry   = numy[NW-1:QW];
      s7_in.nx   = numx[QW-1:0];
      s7_in.ny   = numy[QW-1:0];
      s7_in.qx   = '0;
      s7_in.qy   = '0;
      s7_in.negx = s6_ff.x[XW-1];
      s7_in.negy = s6_ff.y[XW-1];
      s7_in.z    = s6_ff.z;
      s7_in.side.pt   = !s6_ff.zzero && contain;
      s7_in.side.kind = (!s6_ff.zzero && contain) ? KIND_POINT : s6_ff.col_kind;
      s7_in.side.lo   = s6_ff.lo;
      s7_in.side.hi   = s6_ff.hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= req_valid;
         for (int k = 2; k <= 7; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && req_valid) s1_ff <= s1_in;
      if (rdy[2] && v_ff[1])   s2_ff <= s2_in;
      if (rdy[3] && v_ff[2])   s3_ff <= s3_in;
      if (rdy[4] && v_ff[3])   s4_ff <= s4_in;
      if (rdy[5] && v_ff[4])   s5_ff <= s5_in;
      if (rdy[6] && v_ff[5])   s6_ff <= s6_in;
      if (rdy[7] && v_ff[6])   s7_ff <= s7_in;
   end

   assign out_valid = v_ff[7];
   assign out_data  = s7_ff;

endmodule

>>> rtl/sgi_div_step.sv
// sgi_div_step: one restoring division step for both coordinates, one quotient bit each
// depends on sgi_pkg
module sgi_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sgi_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sgi_pkg::div_type out_data
);
   import sgi_pkg::*;

   div_type       step_in, step_ff;
   logic          valid_ff;
   logic [ZW:0]   tx, ty, zz;
   logic          gex, gey;

   always_comb begin
      zz  = {1'b0, in_data.z};
      tx  = {in_data.rx, in_data.nx[QW-1]};
      ty  = {in_data.ry, in_data.ny[QW-1]};
      gex = (tx >= zz);
      gey = (ty >= zz);
      step_in    = in_data;
      step_in.rx = gex ? ZW'(tx - zz) : tx[ZW-1:0];
      step_in.ry = gey ? ZW'(ty - zz) : ty[ZW-1:0];
      step_in.nx = {in_data.nx[QW-2:0], 1'b0};
      step_in.ny = {in_data.ny[QW-2:0], 1'b0};
      step_in.qx = {in_data.qx[QW-2:0], gex};
      step_in.qy = {in_data.qy[QW-2:0], gey};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) step_ff <= step_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule
